### rtl/lfoam_pkg.sv
// ----------------------------------------------------------------------------
// lfoam_pkg
// Shared types and constants of the LFO amplitude modulator: defaults,
// register indexes, fixed-point constants and controller/datapath signals.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lfoam_pkg;

    localparam int PHASE_BITS_DEFAULT     = 32;
    localparam int COS_TABLE_BITS_DEFAULT = 10;

    localparam int SAMPLE_W = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MOD_SHAPE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH      = 2'd2;

    // Modulator shapes.
    localparam logic [1:0] SHAPE_SINE     = 2'd0;
    localparam logic [1:0] SHAPE_SQUARE   = 2'd1;
    localparam logic [1:0] SHAPE_TRIANGLE = 2'd2;
    localparam logic [1:0] SHAPE_SAWTOOTH = 2'd3;

    // Q16 unity, and ceil(2^23 / 255) for the divide-by-255 step.
    localparam logic [16:0] ONE_Q16    = 17'h10000;
    localparam logic [16:0] RECIP_255  = 17'h08081;
    localparam logic [23:0] HALF_255   = 24'd127;

    // Operand selection of the shared multiplier.
    typedef enum logic [1:0] {
        MUL_DEPTH  = 2'd0,
        MUL_RECIP  = 2'd1,
        MUL_SAMPLE = 2'd2
    } mul_sel_t;

    typedef struct packed {
        logic     capture;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     gain_load;
        logic     res_load;
    } dp_cmd_t;

    typedef struct packed {
        logic bypass;
    } dp_status_t;

endpackage

`default_nettype wire

### rtl/lfoam_ctrl.sv
// ----------------------------------------------------------------------------
// lfoam_ctrl
// Sequencer of the modulator: accepts a sample, steps the shared multiplier
// through depth scaling, division by 255 and the sample product, and owns
// the output valid flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lfoam_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output lfoam_pkg::dp_cmd_t         cmd,
    input  wire lfoam_pkg::dp_status_t status
);
    import lfoam_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_DEPTH = 6'b000010,
        S_RECIP = 6'b000100,
        S_GAIN  = 6'b001000,
        S_PROD  = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   accept;
    logic   out_free;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;

    always_comb begin
        state_next    = state_reg;
        cmd.capture   = 1'b0;
        cmd.mul_en    = 1'b0;
        cmd.mul_sel   = MUL_DEPTH;
        cmd.gain_load = 1'b0;
        cmd.res_load  = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    cmd.capture = 1'b1;
                    state_next  = status.bypass ? S_OUT : S_DEPTH;
                end
            end
            S_DEPTH: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_DEPTH;
                state_next  = S_RECIP;
            end
            S_RECIP: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_RECIP;
                state_next  = S_GAIN;
            end
            S_GAIN: begin
                cmd.gain_load = 1'b1;
                state_next    = S_PROD;
            end
            S_PROD: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_SAMPLE;
                state_next  = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.res_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

### rtl/lfoam_datapath.sv
// ----------------------------------------------------------------------------
// lfoam_datapath
// Configuration registers, phase accumulator, quarter-wave cosine table,
// modulator shaping, one shared multiplier and the output data register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lfoam_datapath #(
    parameter int PHASE_BITS     = lfoam_pkg::PHASE_BITS_DEFAULT,
    parameter int COS_TABLE_BITS = lfoam_pkg::COS_TABLE_BITS_DEFAULT
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_valid,
    input  wire logic [lfoam_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [lfoam_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic [lfoam_pkg::SAMPLE_W-1:0]   sample_in,
    output logic      [lfoam_pkg::SAMPLE_W-1:0]   sample_out,
    input  wire lfoam_pkg::dp_cmd_t               cmd,
    output lfoam_pkg::dp_status_t                 status
);
    import lfoam_pkg::*;

    localparam int CTB       = COS_TABLE_BITS;
    localparam int ROM_AW    = CTB - 1;
    localparam int ROM_DEPTH = (1 << (CTB - 2)) + 1;
    localparam logic [CTB-1:0] K_HALF    = CTB'(1) << (CTB - 1);
    localparam logic [CTB-1:0] K_QUARTER = CTB'(1) << (CTB - 2);

    localparam logic [63:0] ONE_Q30    = 64'd1073741824;
    localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

    // Q16 cosine magnitude at cycle position r / 2^tb, for r in the first
    // quarter, from an eight-term Taylor series in Q30. Evaluated at elaboration.
    function automatic logic [16:0] cos_mag(input int unsigned r, input int unsigned tb);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic signed [64:0] sum;
        logic [63:0] rounded;
        x    = (64'(r) * TWO_PI_Q30) >> tb;
        x2   = (x * x) >> 30;
        sum  = 65'(ONE_Q30);
        term = ONE_Q30;
        for (int i = 1; i <= 7; i++) begin
            term = (term * x2) >> 30;
            term = term / 64'((2 * i - 1) * (2 * i));
            if (i % 2 == 1) begin
                sum = sum - 65'(term);
            end else begin
                sum = sum + 65'(term);
            end
        end
        if (sum < 0) begin
            sum = '0;
        end
        if (sum > 65'(ONE_Q30)) begin
            sum = 65'(ONE_Q30);
        end
        rounded = (64'(sum) + 64'd8192) >> 14;
        return rounded[16:0];
    endfunction

    logic [16:0] cos_rom [ROM_DEPTH];

    for (genvar g = 0; g < ROM_DEPTH; g++) begin : g_cos_rom
        assign cos_rom[g] = cos_mag(g, CTB);
    end

    // Configuration and phase.
    logic [1:0]            shape_reg;
    logic [31:0]           step_reg;
    logic [7:0]            depth_reg;
    logic [PHASE_BITS-1:0] phase_reg, phase_next;

    // Per-sample registers.
    logic [SAMPLE_W-1:0] raw_reg;
    logic [SAMPLE_W-1:0] mag_reg;
    logic                neg_reg;
    logic                bypass_reg;
    logic [15:0]         p_reg;
    logic [16:0]         cos_reg;
    logic                cos_neg_reg;
    logic [40:0]         prod_reg;
    logic [23:0]         w_reg;
    logic [16:0]         gain_reg;
    logic [SAMPLE_W-1:0] out_reg;

    logic                bypass_now;
    logic [15:0]         p_now;
    logic [CTB-1:0]      k;
    logic [CTB-1:0]      r1;
    logic [CTB-1:0]      r2;
    logic                k_neg;
    logic [ROM_AW-1:0]   rom_idx;

    logic [17:0]         sine_sum;
    logic [16:0]         m;
    logic [23:0]         w;
    logic [23:0]         mul_a;
    logic [16:0]         mul_b;
    logic [16:0]         q_est;
    logic [24:0]         q_check;
    logic [16:0]         q_div;
    logic [31:0]         rnd;
    logic [SAMPLE_W-1:0] q_out;
    logic [SAMPLE_W-1:0] res;

    assign bypass_now    = (step_reg == 32'd0);
    assign status.bypass = bypass_now;
    assign sample_out    = out_reg;

    assign p_now      = phase_reg[PHASE_BITS-1 -: 16];
    assign phase_next = phase_reg + PHASE_BITS'(step_reg);

    // Fold the table position into the first quarter of the cycle.
    assign k = p_now[15 -: CTB];
    always_comb begin
        r1    = (k > K_HALF) ? (CTB'(0) - k) : k;
        k_neg = 1'b0;
        r2    = r1;
        if (r1 > K_QUARTER) begin
            r2    = K_HALF - r1;
            k_neg = 1'b1;
        end
    end
    assign rom_idx = r2[ROM_AW-1:0];

    // Modulator value in Q16, [0, 1.0].
    always_comb begin
        sine_sum = cos_neg_reg ? (18'(ONE_Q16) - 18'(cos_reg) + 18'd1)
                               : (18'(ONE_Q16) + 18'(cos_reg) + 18'd1);
        case (shape_reg)
            SHAPE_SINE:     m = sine_sum[17:1];
            SHAPE_SQUARE:   m = p_reg[15] ? 17'd0 : ONE_Q16;
            SHAPE_TRIANGLE: m = p_reg[15] ? {1'b0, p_reg[14:0], 1'b0}
                                          : (ONE_Q16 - {p_reg, 1'b0});
            SHAPE_SAWTOOTH: m = ONE_Q16 - 17'(p_reg);
            default:        m = ONE_Q16;
        endcase
    end

    // floor((2*d*m + 255) / 510) equals floor((d*m + 127) / 255).
    assign w = prod_reg[23:0] + HALF_255;

    always_comb begin
        case (cmd.mul_sel)
            MUL_DEPTH: begin
                mul_a = 24'(m);
                mul_b = 17'(depth_reg);
            end
            MUL_RECIP: begin
                mul_a = w;
                mul_b = RECIP_255;
            end
            MUL_SAMPLE: begin
                mul_a = 24'(mag_reg);
                mul_b = gain_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // The reciprocal estimate is high by at most one; check it against w.
    assign q_est   = prod_reg[39:23];
    assign q_check = {q_est, 8'd0} - 25'(q_est);
    assign q_div   = (q_check > 25'(w_reg)) ? (q_est - 17'd1) : q_est;

    assign rnd   = prod_reg[31:0] + 32'd32768;
    assign q_out = rnd[31:16];
    assign res   = bypass_reg ? raw_reg : (neg_reg ? (SAMPLE_W'(0) - q_out) : q_out);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shape_reg <= 2'd0;
            step_reg  <= 32'd0;
            depth_reg <= 8'd0;
            phase_reg <= '0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_MOD_SHAPE:  shape_reg <= cfg_data[1:0];
                    CFG_PHASE_STEP: step_reg  <= cfg_data;
                    CFG_DEPTH:      depth_reg <= cfg_data[7:0];
                    default: begin
                    end
                endcase
            end
            if (cmd.capture && !bypass_now) begin
                phase_reg <= phase_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            raw_reg     <= sample_in;
            neg_reg     <= sample_in[SAMPLE_W-1];
            mag_reg     <= sample_in[SAMPLE_W-1] ? (SAMPLE_W'(0) - sample_in) : sample_in;
            bypass_reg  <= bypass_now;
            p_reg       <= p_now;
            cos_reg     <= cos_rom[rom_idx];
            cos_neg_reg <= k_neg;
        end
        if (cmd.mul_en) begin
            prod_reg <= 41'(mul_a) * 41'(mul_b);
        end
        if (cmd.mul_en && cmd.mul_sel == MUL_RECIP) begin
            w_reg <= w;
        end
        if (cmd.gain_load) begin
            gain_reg <= ONE_Q16 - q_div;
        end
        if (cmd.res_load) begin
            out_reg <= res;
        end
    end

endmodule

`default_nettype wire

### rtl/lfo_amplitude_modulator.sv
// ----------------------------------------------------------------------------
// lfo_amplitude_modulator
// Tremolo: scales each audio sample by an LFO gain between 1 - depth/255
// and 1, with sine, square, triangle or sawtooth modulator shapes.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  s_        in         s_tvalid/s_tready    s_tdata[15:0] sample_in (signed)
//  m_        out        m_tvalid/m_tready    m_tdata[15:0] sample_out (signed)
//  cfg_      in         cfg_valid/cfg_ready  cfg_index[1:0], cfg_data[31:0]
//
//  An accepted sample goes through a capture state, three passes through the
//  one shared 24x17 multiplier (depth scaling, divide by 255, then after a
//  gain load state the sample product) and the output load state; a new beat
//  is accepted only once the controller is back in idle after the output load.
//  With phase_step at zero a sample goes from capture straight to the output load.
//  The output register lets the next sample be accepted while a result waits.
//  Reset is synchronous and active low; it clears the configuration registers,
//  the phase and the controller. A stalled output holds the controller in its final state until taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lfo_amplitude_modulator #(
    parameter int PHASE_BITS     = lfoam_pkg::PHASE_BITS_DEFAULT,
    parameter int COS_TABLE_BITS = lfoam_pkg::COS_TABLE_BITS_DEFAULT
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [lfoam_pkg::SAMPLE_W-1:0]   s_tdata,   // [15:0] sample_in
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic      [lfoam_pkg::SAMPLE_W-1:0]   m_tdata,   // [15:0] sample_out
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [lfoam_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [lfoam_pkg::CFG_DATA_W-1:0] cfg_data
);
    import lfoam_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    lfoam_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    lfoam_datapath #(
        .PHASE_BITS     (PHASE_BITS),
        .COS_TABLE_BITS (COS_TABLE_BITS)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .sample_in  (s_tdata),
        .sample_out (m_tdata),
        .cmd        (cmd),
        .status     (status)
    );

endmodule

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the LFO amplitude modulator. A short directed table
// covers bypass, the gain extremes, every shape, depth zero and a write to an
// unmapped register. A long random run follows with changing settings. Every
// output beat is checked against a bit-exact model of the tremolo gain kept
// in this file, while both stream sides insert random gaps and stalls.
// ----------------------------------------------------------------------------

module tb;
    import lfoam_pkg::*;

    localparam int           RANDOM_ITEMS = 1500;
    localparam int           HOLD_CYCLES  = 300;
    localparam int           IDLE_LIMIT   = 3000;
    localparam int           TAIL_CYCLES  = 20;
    localparam logic [1:0]   CFG_UNMAPPED = 2'd3;
    localparam longint       Q30_ONE      = 64'd1073741824;
    localparam longint       TWO_PI_Q30   = 64'd6746518852;
    localparam logic [31:0]  STEP_MAX     = 32'h8000_0000;

    typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [1:0]  index;
        logic [31:0] data;
        bit          known;
        logic [15:0] want;
    } row_t;

    typedef struct {
        bit          known;
        logic [15:0] want;
    } pinned_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [SAMPLE_W-1:0]   s_tdata;     // [15:0] sample_in
    logic                  m_tvalid;
    logic                  m_tready;
    logic [SAMPLE_W-1:0]   m_tdata;     // [15:0] sample_out
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    lfo_amplitude_modulator uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Model state, updated only by the monitor.
    logic [1:0]  shape_r;
    logic [31:0] step_r;
    logic [7:0]  depth_r;
    logic [31:0] phase_acc;

    logic [15:0] scaled_q[$];
    pinned_t     pinned_q[$];
    row_t        rows[$];

    bit quiet;
    bit hold_req;
    int mismatches;
    int samples_sent;
    int results_checked;
    int writes_done;
    int idle_run;

    initial begin
        aclk = 1'b0;
    end

    always #5 aclk = ~aclk;

    // Q16 cosine of k / 2^COS_TABLE_BITS from an eight-term Taylor series in Q30.
    function automatic longint lfo_cosine(longint k);
        longint unsigned n, r, x, x2, term;
        longint acc;
        bit neg;
        n = longint'(1) << COS_TABLE_BITS_DEFAULT;
        r = k & (n - 1);
        neg = 1'b0;
        if (r > n / 2) r = n - r;
        if (r > n / 4) begin
            r = n / 2 - r;
            neg = 1'b1;
        end
        x = r * TWO_PI_Q30 / n;
        x2 = (x * x) >> 30;
        acc = Q30_ONE;
        term = Q30_ONE;
        for (int i = 1; i <= 7; i++) begin
            term = (term * x2) >> 30;
            term = term / longint'((2 * i - 1) * (2 * i));
            if (i % 2 == 1) acc = acc - longint'(term);
            else acc = acc + longint'(term);
        end
        if (acc < 0) acc = 0;
        if (acc > Q30_ONE) acc = Q30_ONE;
        acc = (acc + 8192) >>> 14;
        return neg ? -acc : acc;
    endfunction

    // Modulator value in Q16, 0 to 65536, for the top 16 phase bits.
    function automatic longint shape_level(longint p);
        case (shape_r)
            SHAPE_SINE: begin
                return (65536 + lfo_cosine(p >>> (16 - COS_TABLE_BITS_DEFAULT)) + 1) >>> 1;
            end
            SHAPE_SQUARE: begin
                return (p < 32768) ? 65536 : 0;
            end
            SHAPE_TRIANGLE: begin
                return (p < 32768) ? 65536 - 2 * p : 2 * p - 65536;
            end
            default: begin
                return 65536 - p;
            end
        endcase
    endfunction

    // Scales one sample by the current gain and advances the phase; a zero step passes it through.
    function automatic logic [15:0] tremolo_sample(logic [15:0] raw);
        longint mag, level, gain, q;
        logic [16:0] signed_q;
        if (step_r == 32'd0) return raw;
        mag = raw[15] ? 65536 - longint'(raw) : longint'(raw);
        level = shape_level(longint'(phase_acc[31:16]));
        gain = 65536 - (2 * longint'(depth_r) * level + 255) / 510;
        q = (mag * gain + 32768) >>> 16;
        signed_q = raw[15] ? 17'(65536 - q) : 17'(q);
        phase_acc = phase_acc + step_r;
        return signed_q[15:0];
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("%0t ns: mismatch on %s: got %h, wanted %h", $time, what, got, want);
        mismatches++;
    endtask

    // Monitor: follows register writes, predicts at input beats, checks output beats.
    always @(posedge aclk) begin
        logic [15:0] want;
        pinned_t pin;
        if (!aresetn) begin
            shape_r = SHAPE_SINE;
            step_r = '0;
            depth_r = '0;
            phase_acc = '0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (scaled_q.size() == 0) begin
                    report_mismatch("unexpected output beat", m_tdata, 16'h0000);
                end else begin
                    want = scaled_q.pop_front();
                    results_checked++;
                    if (m_tdata !== want) report_mismatch("sample_out", m_tdata, want);
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_MOD_SHAPE:  shape_r = cfg_data[1:0];
                    CFG_PHASE_STEP: step_r = cfg_data;
                    CFG_DEPTH:      depth_r = cfg_data[7:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                want = tremolo_sample(s_tdata);
                pin = pinned_q.pop_front();
                if (pin.known) want = pin.want;
                scaled_q.push_back(want);
            end
        end
    end

    // Watchdog on beats of any channel.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            idle_run <= 0;
        end else if (idle_run >= IDLE_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                     IDLE_LIMIT, scaled_q.size());
            $display("status: fail");
            $finish;
        end else begin
            idle_run <= idle_run + 1;
        end
    end

    // Mostly short gaps, a few long ones, none while quiet.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 11))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    function automatic logic [31:0] pick_step();
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return 32'd1;
            2:       return STEP_MAX;
            3, 4, 5: return $urandom_range(1, 32'h0100_0000);
            default: return $urandom_range(1, STEP_MAX);
        endcase
    endfunction

    // Output side: random stalls, plus one long hold-off on request.
    initial begin
        int stall;
        m_tready = 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else begin
                stall = pick_gap();
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    task automatic put_sample(logic [15:0] value, bit known, logic [15:0] want);
        int gap;
        pinned_q.push_back('{known, want});
        s_tvalid <= 1'b1;
        s_tdata <= value;
        do @(posedge aclk); while (!s_tready);
        samples_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic sender_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic drain();
        while (scaled_q.size() != 0) @(posedge aclk);
    endtask

    // Registers change only with the input idle and every result taken.
    task automatic write_reg(logic [1:0] index, logic [31:0] value);
        sender_idle();
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        writes_done++;
        @(posedge aclk);
    endtask

    function automatic void add_write(logic [1:0] index, logic [31:0] value);
        rows.push_back('{ROW_WRITE, index, value, 1'b0, 16'h0000});
    endfunction

    function automatic void add_sample(logic [15:0] value, bit known, logic [15:0] want);
        rows.push_back('{ROW_SAMPLE, CFG_UNMAPPED, {16'h0000, value}, known, want});
    endfunction

    initial begin
        int sent;
        int phase_no;
        int n;
        int first;
        logic [31:0] regs[3];

        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        aresetn = 1'b0;
        quiet = 1'b0;
        hold_req = 1'b0;
        mismatches = 0;
        samples_sent = 0;
        results_checked = 0;
        writes_done = 0;
        idle_run = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Out of reset the step is zero, so samples pass straight through.
        add_sample(16'h8000, 1'b1, 16'h8000);
        add_sample(16'h7FFF, 1'b1, 16'h7FFF);
        add_sample(16'h0000, 1'b1, 16'h0000);
        add_sample(16'hFFFF, 1'b1, 16'hFFFF);
        add_sample(16'h0001, 1'b1, 16'h0001);
        // Full depth square at half-cycle steps: the gain alternates 0 and 1.
        add_write(CFG_DEPTH, 32'd255);
        add_write(CFG_PHASE_STEP, STEP_MAX);
        add_write(CFG_MOD_SHAPE, {30'd0, SHAPE_SQUARE});
        add_sample(16'h7FFF, 1'b1, 16'h0000);
        add_sample(16'h8000, 1'b1, 16'h8000);
        add_sample(16'h8000, 1'b1, 16'h0000);
        // The phase carries over when the shape changes.
        add_write(CFG_MOD_SHAPE, {30'd0, SHAPE_SAWTOOTH});
        add_sample(16'h7FFF, 1'b0, 16'h0000);
        add_sample(16'hC000, 1'b0, 16'h0000);
        add_write(CFG_MOD_SHAPE, {30'd0, SHAPE_SINE});
        add_write(CFG_PHASE_STEP, 32'h0100_0000);
        add_write(CFG_DEPTH, 32'd200);
        add_sample(16'hCFC7, 1'b0, 16'h0000);
        add_sample(16'h3039, 1'b0, 16'h0000);
        add_sample(16'h8001, 1'b0, 16'h0000);
        add_write(CFG_MOD_SHAPE, {30'd0, SHAPE_TRIANGLE});
        add_write(CFG_PHASE_STEP, 32'h1234_5679);
        add_sample(16'h7FFF, 1'b0, 16'h0000);
        add_sample(16'h8000, 1'b0, 16'h0000);
        add_sample(16'h5A5A, 1'b0, 16'h0000);
        // Zero depth gives unity gain while the phase keeps moving.
        add_write(CFG_DEPTH, 32'd0);
        add_sample(16'h8000, 1'b1, 16'h8000);
        add_sample(16'h7FFF, 1'b1, 16'h7FFF);
        // A write to the unmapped index must leave every register alone.
        add_write(CFG_DEPTH, 32'd1);
        add_write(CFG_UNMAPPED, 32'hFFFF_FFFF);
        add_sample(16'hA5A5, 1'b0, 16'h0000);

        foreach (rows[i]) begin
            if (rows[i].kind == ROW_WRITE) write_reg(rows[i].index, rows[i].data);
            else put_sample(rows[i].data[15:0], rows[i].known, rows[i].want);
        end

        sent = 0;
        phase_no = 0;
        while (sent < RANDOM_ITEMS) begin
            quiet = (phase_no % 7 == 3);
            regs[CFG_MOD_SHAPE] = {30'd0, 2'($urandom_range(0, 3))};
            regs[CFG_PHASE_STEP] = pick_step();
            case ($urandom_range(0, 4))
                0:       regs[CFG_DEPTH] = 32'd0;
                1:       regs[CFG_DEPTH] = 32'd255;
                default: regs[CFG_DEPTH] = $urandom_range(0, 255);
            endcase
            if (phase_no == 0) begin
                regs[CFG_PHASE_STEP] = STEP_MAX;
                regs[CFG_DEPTH] = 32'd255;
            end else if (phase_no == 1) begin
                regs[CFG_PHASE_STEP] = 32'd1;
            end
            first = $urandom_range(0, 2);
            for (int k = 0; k < 3; k++) write_reg(2'((first + k) % 3), regs[(first + k) % 3]);
            if (phase_no % 6 == 4) write_reg(CFG_UNMAPPED, $urandom);

            n = $urandom_range(40, 110);
            if (phase_no == 2) hold_req = 1'b1;
            for (int i = 0; i < n; i++) begin
                if (i == n / 2 && phase_no % 5 == 1) begin
                    sender_idle();
                    drain();
                end
                put_sample(pick_sample(), 1'b0, 16'h0000);
            end
            sent += n;
            phase_no++;
        end
        quiet = 1'b0;

        sender_idle();
        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("run covered %0d samples and %0d register writes over %0d random settings,",
                 samples_sent, writes_done, phase_no);
        $display("with %0d output beats checked across all shapes, bypass and depth extremes",
                 results_checked);
        if (mismatches == 0 && scaled_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
